// ===== hw/rtl/itr_pkg.sv =====
package itr_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int BASE_BITS      = 6;
    localparam int CHAR_BITS      = 8;

    localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_BITS-1:0] BASE_TEN   = 6'd10;
    localparam logic [BASE_BITS-1:0] DIGIT_NINE = 6'd9;
    localparam logic [BASE_BITS-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

    // digit 0..35 -> '0'..'9', 'a'..'z'
    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [BASE_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d > DIGIT_NINE) begin
            c = {2'b00, d - DIGIT_TEN} + CHAR_A;
        end else begin
            c = {2'b00, d} + CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/itr_queue.sv =====
module itr_queue #(
    parameter int WIDTH = 39
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/itr_front.sv =====
module itr_front #(
    parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [VALUE_BITS-1:0]           i_value,
    input  logic [itr_pkg::BASE_BITS-1:0]          i_base,
    output logic                                   o_push_valid,
    input  logic                                   i_push_ready,
    output logic [VALUE_BITS+itr_pkg::BASE_BITS:0] o_push_data
);

    logic [itr_pkg::BASE_BITS-1:0] base_c;
    logic                          neg;
    logic [VALUE_BITS-1:0]         mag;

    // clamp base into 2..36
    always_comb begin
        if (i_base < itr_pkg::BASE_MIN) begin
            base_c = itr_pkg::BASE_MIN;
        end else if (i_base > itr_pkg::BASE_MAX) begin
            base_c = itr_pkg::BASE_MAX;
        end else begin
            base_c = i_base;
        end
    end

    // sign only in base ten; elsewhere raw bits read unsigned
    assign neg = i_value[VALUE_BITS-1] && (base_c == itr_pkg::BASE_TEN);
    assign mag = neg ? (~i_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_value;

    assign o_push_valid = i_valid;
    assign o_ready      = i_push_ready;
    assign o_push_data  = {neg, base_c, mag};

endmodule

// ===== hw/rtl/itr_back.sv =====
module itr_back #(
    parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_job_valid,
    output logic                                   o_job_pop,
    input  logic [VALUE_BITS+itr_pkg::BASE_BITS:0] i_job_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [itr_pkg::CHAR_BITS-1:0]          o_character,
    output logic                                   o_last
);

    localparam int IW = $clog2(VALUE_BITS);
    localparam int BW = itr_pkg::BASE_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_RD   = 5'b01000,
        S_WR   = 5'b10000
    } t_state;

    t_state                        r_state;
    logic [VALUE_BITS-1:0]         r_quo;
    logic [BW-1:0]                 r_rem;
    logic [BW-1:0]                 r_base;
    logic                          r_neg;
    logic [IW-1:0]                 r_step;
    logic [IW-1:0]                 r_wr;
    logic [IW-1:0]                 r_rd;
    logic [BW-1:0]                 r_rdata;
    logic [BW-1:0]                 r_dig [VALUE_BITS];
    logic                          r_ovalid;
    logic [itr_pkg::CHAR_BITS-1:0] r_ochar;
    logic                          r_olast;

    logic [BW:0]           rem_sh;
    logic                  ge;
    logic [BW-1:0]         n_rem;
    logic [VALUE_BITS-1:0] n_quo;
    logic                  last_step;
    logic                  slot_free;
    logic                  load_out;

    // one restoring-division step per cycle
    assign rem_sh    = {r_rem, r_quo[VALUE_BITS-1]};
    assign ge        = (rem_sh >= {1'b0, r_base});
    assign n_rem     = ge ? BW'(rem_sh - {1'b0, r_base}) : rem_sh[BW-1:0];
    assign n_quo     = {r_quo[VALUE_BITS-2:0], ge};
    assign last_step = (r_step == IW'(VALUE_BITS - 1));
    assign slot_free = !r_ovalid || i_ready;
    assign load_out  = ((r_state == S_SIGN) || (r_state == S_WR)) && slot_free;

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_valid     = r_ovalid;
    assign o_character = r_ochar;
    assign o_last      = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (last_step && (n_quo == '0)) begin
                        r_state <= r_neg ? S_SIGN : S_RD;
                    end
                end
                S_SIGN: begin
                    if (slot_free) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (slot_free) begin
                        r_state <= (r_rd == '0) ? S_IDLE : S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_quo  <= i_job_data[VALUE_BITS-1:0];
                r_base <= i_job_data[VALUE_BITS+BW-1:VALUE_BITS];
                r_neg  <= i_job_data[VALUE_BITS+BW];
                r_rem  <= '0;
                r_step <= '0;
                r_wr   <= '0;
            end
            S_DIV: begin
                if (last_step) begin
                    r_dig[r_wr] <= n_rem;
                    r_rd        <= r_wr;
                    r_wr        <= r_wr + IW'(1);
                    r_rem       <= '0;
                    r_step      <= '0;
                end else begin
                    r_rem  <= n_rem;
                    r_step <= r_step + IW'(1);
                end
                r_quo <= n_quo;
            end
            S_SIGN: begin
                if (slot_free) begin
                    r_ochar <= itr_pkg::CHAR_MINUS;
                    r_olast <= 1'b0;
                end
            end
            S_RD: begin
                r_rdata <= r_dig[r_rd];
            end
            S_WR: begin
                if (slot_free) begin
                    r_ochar <= itr_pkg::digit_char(r_rdata);
                    r_olast <= (r_rd == '0);
                    r_rd    <= r_rd - IW'(1);
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

// ===== hw/rtl/integer_to_radix_ascii.sv =====
// The back end has a single shift-subtract divider, one bit per cycle; it
// yields the digits of an item low first, and the back end takes a new item
// from the queue only once every character of the last one has been loaded
// into the output register.
// Reset: synchronous, active low; clears queue, sequencer and output valid.
module integer_to_radix_ascii #(
    parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [VALUE_BITS-1:0]         i_value,
    input  logic [itr_pkg::BASE_BITS-1:0]        i_base,
    // character channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [itr_pkg::CHAR_BITS-1:0]        o_character,
    output logic                                 o_last
);

    // queued job: {neg, clamped base, magnitude}
    localparam int JW = VALUE_BITS + itr_pkg::BASE_BITS + 1;

    logic          push_valid;
    logic          push_ready;
    logic [JW-1:0] push_data;
    logic          job_valid;
    logic          job_pop;
    logic [JW-1:0] job_data;

    // Front: clamps base, resolves sign, takes magnitude. Combinational; it takes
    // an item whenever the queue has room.
    itr_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_base       (i_base),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Two-deep queue so items keep arriving while the back end is dividing.
    itr_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (job_valid),
        .i_pop        (job_pop),
        .o_pop_data   (job_data)
    );

    // Back: repeated division by the base yields digits low first into a
    // small store; they are then read out high first through the output
    // register, with the minus sign ahead of them when needed.
    itr_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job_data  (job_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ===== hw/rtl/itr_checker.sv =====
module itr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [itr_pkg::CHAR_BITS-1:0] o_character,
    input logic                          o_last
);

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output item changed while stalled");

    // only digits, lower-case letters or minus
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_character >= 8'h30 && o_character <= 8'h39) ||
                     (o_character >= 8'h61 && o_character <= 8'h7A) ||
                     (o_character == itr_pkg::CHAR_MINUS)))
        else $error("illegal character");

    // a minus sign is always followed by digits
    a_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == itr_pkg::CHAR_MINUS) |-> !o_last)
        else $error("minus sign marked last");

    // nothing shown right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind integer_to_radix_ascii itr_checker u_itr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int VALUE_BITS  = itr_pkg::VALUE_BITS_DEF;
    localparam int HOLD_CYCLES = 3000;   // long receiver hold-off, fills the block
    localparam int TAIL_CYCLES = 1200;   // > one worst-case item (base two, 32 digits)
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [itr_pkg::CHAR_BITS-1:0] ch;
        logic                          last;
    } t_text_char;

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_WAVE} t_rx_mode;

    logic                                i_clk   = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic signed [VALUE_BITS-1:0]        i_value = '0;
    logic [itr_pkg::BASE_BITS-1:0]       i_base  = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [itr_pkg::CHAR_BITS-1:0]       o_character;
    logic                                o_last;

    t_text_char pending_chars[$];
    int         mismatches = 0;

    // sender pacing
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // receiver control: tests request a hold by bumping hold_req
    bit       rx_free   = 1'b0;
    int       hold_req  = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    t_rx_mode rx_mode   = RX_OPEN;
    int       rx_left   = 0;
    int       rx_tick   = 0;

    integer_to_radix_ascii #(.VALUE_BITS(VALUE_BITS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_base      (i_base),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Expected text for one value: digits msd first, '-' only for a
    // negative value in base ten, out-of-range bases clamped to 2..36.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                         input logic [itr_pkg::BASE_BITS-1:0] base);
        logic [itr_pkg::BASE_BITS-1:0] radix;
        logic [VALUE_BITS-1:0]         divisor;
        logic [VALUE_BITS-1:0]         mag;
        logic [itr_pkg::CHAR_BITS-1:0] digits[$];
        logic                          neg;
        int                            d;
        t_text_char                    t;
        radix = (base < itr_pkg::BASE_MIN) ? itr_pkg::BASE_MIN :
                (base > itr_pkg::BASE_MAX) ? itr_pkg::BASE_MAX : base;
        divisor = VALUE_BITS'(radix);
        neg = value[VALUE_BITS-1] && (radix == itr_pkg::BASE_TEN);
        // most negative value: two's complement negate wraps to 2^(N-1), read unsigned
        mag = neg ? -value : value;
        if (mag == '0) begin
            digits.push_front(itr_pkg::CHAR_ZERO);
        end
        while (mag != '0) begin
            d = int'(mag % divisor);
            if (d > int'(itr_pkg::DIGIT_NINE)) begin
                digits.push_front(itr_pkg::CHAR_A +
                                  itr_pkg::CHAR_BITS'(d - int'(itr_pkg::DIGIT_TEN)));
            end else begin
                digits.push_front(itr_pkg::CHAR_ZERO + itr_pkg::CHAR_BITS'(d));
            end
            mag = mag / divisor;
        end
        if (neg) begin
            digits.push_front(itr_pkg::CHAR_MINUS);
        end
        foreach (digits[k]) begin
            t.ch   = digits[k];
            t.last = (k == digits.size() - 1);
            pending_chars.push_back(t);
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        logic [VALUE_BITS-1:0] v;
        int                    width;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: ;                                  // full-width random bits
            3, 4:    v = $urandom_range(0, 99);
            5, 6, 7: begin
                width = $urandom_range(1, VALUE_BITS);
                v = v & VALUE_BITS'((64'd1 << width) - 64'd1);
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
            8: begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    2:       v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                    default: v = '1;
                endcase
            end
            default: v = -VALUE_BITS'($urandom_range(1, 1000));
        endcase
        return v;
    endfunction

    function automatic logic [itr_pkg::BASE_BITS-1:0] rand_base();
        logic [itr_pkg::BASE_BITS-1:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: b = itr_pkg::BASE_BITS'($urandom_range(itr_pkg::BASE_MIN,
                                                                     itr_pkg::BASE_MAX));
            6, 7:             b = itr_pkg::BASE_TEN;
            8: begin
                case ($urandom_range(0, 2))
                    0:       b = itr_pkg::BASE_MIN;
                    1:       b = 6'd16;
                    default: b = itr_pkg::BASE_MAX;
                endcase
            end
            default:          b = itr_pkg::BASE_BITS'($urandom_range(0, 63));  // incl. out of range
        endcase
        return b;
    endfunction

    // Present one item and hold it until accepted. Valid is left high so a
    // back-to-back call keeps the channel busy without a bubble.
    task automatic send_item(input logic [VALUE_BITS-1:0] value,
                             input logic [itr_pkg::BASE_BITS-1:0] base);
        i_valid <= 1'b1;
        i_value <= value;
        i_base  <= base;
        do @(posedge i_clk); while (!o_ready);
        predict_text(value, base);
    endtask

    // Send plus burst/gap pacing.
    task automatic offer(input logic [VALUE_BITS-1:0] value,
                         input logic [itr_pkg::BASE_BITS-1:0] base);
        send_item(value, base);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop offering and wait until every expected character has come.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        offer('0, itr_pkg::BASE_TEN);
        offer('0, itr_pkg::BASE_MIN);
        offer('0, itr_pkg::BASE_MAX);
        offer(32'h7FFF_FFFF, itr_pkg::BASE_TEN);
        offer(32'h8000_0000, itr_pkg::BASE_TEN);       // most negative: no overflow
        offer(-32'sd1, itr_pkg::BASE_TEN);
        offer(-32'sd1, itr_pkg::BASE_MIN);             // 32 characters
        offer(32'h8000_0000, itr_pkg::BASE_MIN);
        offer(-32'sd1, 6'd16);                         // negative, not base ten: unsigned
        offer(-32'sd123, 6'd8);
        offer(32'd1234567890, itr_pkg::BASE_TEN);
        offer(-32'sd987654321, itr_pkg::BASE_TEN);
        offer(32'd35, itr_pkg::BASE_MAX);              // 'z'
        offer(32'd10, 6'd11);                          // 'a'
        offer(32'd9, itr_pkg::BASE_TEN);
        offer(32'd255, 6'd0);                          // base below range
        offer(32'd255, 6'd1);
        offer(32'd12345, 6'd37);                       // base above range
        offer(32'd12345, 6'd63);
        offer(32'h7FFF_FFFF, itr_pkg::BASE_MAX);
        offer(32'd1, itr_pkg::BASE_MIN);
        offer(32'hDEAD_BEEF, 6'd16);
        offer(-32'sd36, itr_pkg::BASE_MAX);
        offer(32'd1295, itr_pkg::BASE_MAX);            // "zz"
        offer(32'd8, 6'd3);
        wait_drained();
    endtask

    task automatic test_random_text(input int count);
        repeat (count) offer(rand_value(), rand_base());
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing,
    // so the block's queue fills and o_ready drops.
    task automatic test_backpressure(input int count);
        gaps_on = 1'b0;
        hold_req++;
        repeat (count) offer(rand_value(), rand_base());
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // Small groups, each fully drained before the next one starts.
    task automatic test_drained_groups(input int groups, input int per_group);
        repeat (groups) begin
            repeat (per_group) offer(rand_value(), rand_base());
            wait_drained();
        end
    endtask

    // No idling on either side.
    task automatic test_full_rate(input int count);
        gaps_on = 1'b0;
        rx_free = 1'b1;
        repeat (count) offer(rand_value(), rand_base());
        wait_drained();
        rx_free = 1'b0;
        gaps_on = 1'b1;
    endtask

    // Receiver: long hold-off on request, otherwise a randomly chosen
    // stall pattern that is held for a random stretch, then chosen anew.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_free) begin
            i_ready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 400);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:   i_ready <= rx_tick[2];
            endcase
        end
    end

    // Character checker: every accepted character against the oldest expected one.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected char %h last %b at %0t", o_character, o_last,
                             $realtime);
                end
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.ch || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch at %0t: expected char %h last %b, got char %h last %b",
                                 $realtime, want.ch, want.last, o_character, o_last);
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_text(300);
        test_backpressure(40);
        test_drained_groups(5, 10);
        test_full_rate(45);
        // Any stray character after the drain shows up within one item time.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
